@@ sv/julia_escape_time_macros.svh @@
// assertion helpers shared by the julia block
`ifndef JULIA_ESCAPE_TIME_MACROS_SVH
`define JULIA_ESCAPE_TIME_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define JET_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JET_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/jet_pkg.sv @@
`timescale 1ns / 1ps

package jet_pkg;

    localparam int FRAC_BITS = 28;
    localparam int MAX_LEVEL = 255;
    localparam int LVL_W     = $clog2(MAX_LEVEL + 1);
    localparam int LEVEL_W   = 8;
    localparam int PREC_W    = 5;
    localparam int IDX_W     = 2;

    // register indexes of the config port
    localparam logic [IDX_W-1:0] REG_C_REAL    = 2'd0;
    localparam logic [IDX_W-1:0] REG_C_IMAG    = 2'd1;
    localparam logic [IDX_W-1:0] REG_PRECISION = 2'd2;

    localparam logic signed [31:0] C_REAL_RST    = -32'sd26843546;
    localparam logic signed [31:0] C_IMAG_RST    = 32'sd174483046;
    localparam logic [PREC_W-1:0]  PRECISION_RST = 5'd1;

    // escape when re^2 + im^2 >= 4.0 at the product scale
    localparam logic [63:0] MAG_THRESH = 64'd4 << (2 * FRAC_BITS);

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_RR,
        ST_MUL_II,
        ST_MUL_RI,
        ST_CHECK,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_RR,
        OP_II,
        OP_RI
    } mul_op_t;

    typedef struct packed {
        mul_op_t              op;
        logic                 in_ready;
        logic                 load;
        logic                 cap_rr;
        logic                 cap_ii;
        logic                 cap_ri;
        logic                 update;
        logic                 finish;
        logic [LEVEL_W-1:0]   res;
    } ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = 32'sh7fffffff;
        else if (v < S32_MIN)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ sv/jet_mul.sv @@
`timescale 1ns / 1ps

module jet_mul (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] prod
);

    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;

    assign prod_next = a * b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ sv/jet_ctrl.sv @@
`timescale 1ns / 1ps
`include "julia_escape_time_macros.svh"

module jet_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [jet_pkg::PREC_W-1:0] prec,
    input  logic                       escaped,
    input  logic                       out_busy,
    output jet_pkg::ctl_t              ctl
);

    jet_pkg::state_t state_reg, state_next;

    logic [jet_pkg::PREC_W-1:0]  prec_reg, prec_next;
    logic [jet_pkg::PREC_W-1:0]  sub_reg, sub_next;
    logic [jet_pkg::LVL_W-1:0]   lvl_reg, lvl_next;
    logic [jet_pkg::LEVEL_W-1:0] res_reg, res_next;
    logic                        first_reg, first_next;

    logic start;
    logic last_step;
    logic [jet_pkg::LEVEL_W-1:0] lvl_sat;
    logic [jet_pkg::LEVEL_W-1:0] max_sat;

    assign start     = (state_reg == jet_pkg::ST_IDLE) && in_valid;
    assign last_step = (lvl_reg == jet_pkg::LVL_W'(jet_pkg::MAX_LEVEL - 1))
                       && (sub_reg == prec_reg - jet_pkg::PREC_W'(1));

    // clamp to the 8-bit output
    assign lvl_sat = (32'(lvl_reg) > 32'(255)) ? 8'd255 : jet_pkg::LEVEL_W'(lvl_reg);
    assign max_sat = (jet_pkg::MAX_LEVEL > 255) ? 8'd255
                                                : jet_pkg::LEVEL_W'(jet_pkg::MAX_LEVEL);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jet_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (prec == '0) ? jet_pkg::ST_DONE : jet_pkg::ST_MUL_RR;
                end
            end
            jet_pkg::ST_MUL_RR: state_next = jet_pkg::ST_MUL_II;
            jet_pkg::ST_MUL_II: state_next = jet_pkg::ST_MUL_RI;
            jet_pkg::ST_MUL_RI: state_next = jet_pkg::ST_CHECK;
            jet_pkg::ST_CHECK:
            begin
                if (!first_reg && (escaped || last_step))
                    state_next = jet_pkg::ST_DONE;
                else
                    state_next = jet_pkg::ST_UPDATE;
            end
            jet_pkg::ST_UPDATE: state_next = jet_pkg::ST_MUL_RR;
            jet_pkg::ST_DONE:
            begin
                if (!out_busy)
                    state_next = jet_pkg::ST_IDLE;
            end
            default: state_next = jet_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl          = '0;
        ctl.op       = jet_pkg::OP_RR;
        ctl.in_ready = (state_reg == jet_pkg::ST_IDLE);
        ctl.load     = start;
        ctl.res      = res_reg;
        unique case (state_reg)
            jet_pkg::ST_MUL_RR: ctl.op = jet_pkg::OP_RR;
            jet_pkg::ST_MUL_II:
            begin
                ctl.op     = jet_pkg::OP_II;
                ctl.cap_rr = 1'b1;
            end
            jet_pkg::ST_MUL_RI:
            begin
                ctl.op     = jet_pkg::OP_RI;
                ctl.cap_ii = 1'b1;
            end
            jet_pkg::ST_CHECK:  ctl.cap_ri = 1'b1;
            jet_pkg::ST_UPDATE: ctl.update = 1'b1;
            jet_pkg::ST_DONE:   ctl.finish = !out_busy;
            default:            ctl.op = jet_pkg::OP_RR;
        endcase
    end

    always_comb
    begin
        prec_next  = prec_reg;
        sub_next   = sub_reg;
        lvl_next   = lvl_reg;
        res_next   = res_reg;
        first_next = first_reg;
        if (start)
        begin
            prec_next  = prec;
            sub_next   = '0;
            lvl_next   = '0;
            first_next = 1'b1;
            res_next   = max_sat;
        end
        else if (state_reg == jet_pkg::ST_CHECK && !first_reg)
        begin
            if (escaped)
                res_next = lvl_sat;
            else if (last_step)
                res_next = max_sat;
            else if (sub_reg == prec_reg - jet_pkg::PREC_W'(1))
            begin
                // step count crosses a multiple of precision
                sub_next = '0;
                lvl_next = lvl_reg + jet_pkg::LVL_W'(1);
            end
            else
                sub_next = sub_reg + jet_pkg::PREC_W'(1);
        end
        else if (state_reg == jet_pkg::ST_UPDATE)
            first_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jet_pkg::ST_IDLE;
            prec_reg  <= '0;
            sub_reg   <= '0;
            lvl_reg   <= '0;
            res_reg   <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            prec_reg  <= prec_next;
            sub_reg   <= sub_next;
            lvl_reg   <= lvl_next;
            res_reg   <= res_next;
            first_reg <= first_next;
        end
    end

    `JET_ASSERT_IMP(a_sub_in_range,
        (state_reg != jet_pkg::ST_IDLE && state_reg != jet_pkg::ST_DONE),
        (sub_reg < prec_reg), "sub-step counter reached precision")

    `JET_ASSERT_IMP(a_lvl_in_range,
        (state_reg != jet_pkg::ST_IDLE && state_reg != jet_pkg::ST_DONE),
        (32'(lvl_reg) < jet_pkg::MAX_LEVEL), "level counter passed the limit")

    `JET_ASSERT_NXT(a_escape_ends,
        (state_reg == jet_pkg::ST_CHECK && !first_reg && escaped),
        (state_reg == jet_pkg::ST_DONE && res_reg == $past(lvl_sat)),
        "escape did not end the point with the current level")

endmodule

@@ sv/julia_escape_time.sv @@
`timescale 1ns / 1ps
// julia set escape-time engine
// input channel in_valid/in_ready carries one start point (point_real, point_imag),
// signed Q4.28. output channel out_valid/out_ready returns one level per point.
// config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes c_real (0),
// c_imag (1) and precision (2); other indexes are dropped. cfg_ready is always high,
// and config is meant to change only while no point is in flight.
// each point runs z = z*z + c until |z|^2 >= 4 or 255 * precision iterations.
// one 32x32 multiplier does all three products of an iteration in turn, so an
// iteration runs as three products, an escape check and an update.
// precision 0 gives level 255 without iterating.
// one point at a time: in_ready is high only while the engine is idle, but a new
// point is taken while the previous level still waits in the output register.
// if out_ready stays low the engine holds its finished level and waits.
// reset restores c = -0.1 + 0.65i, precision 1, and empties the output register.
module julia_escape_time (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [31:0]                  point_real,
    input  logic signed [31:0]                  point_imag,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [jet_pkg::LEVEL_W-1:0]         level,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jet_pkg::IDX_W-1:0]           cfg_index,
    input  logic [31:0]                         cfg_data
);

    jet_pkg::ctl_t ctl;

    logic signed [31:0]         c_real_reg, c_real_next;
    logic signed [31:0]         c_imag_reg, c_imag_next;
    logic [jet_pkg::PREC_W-1:0] prec_reg, prec_next;

    logic signed [31:0] re_reg, re_next;
    logic signed [31:0] im_reg, im_next;
    logic signed [63:0] rr_reg, rr_next;
    logic signed [63:0] ii_reg, ii_next;
    logic signed [63:0] ri_reg, ri_next;

    logic                        out_valid_reg, out_valid_next;
    logic [jet_pkg::LEVEL_W-1:0] level_reg, level_next;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod;
    logic signed [63:0] diff;
    logic signed [63:0] nr_wide;
    logic signed [63:0] ni_wide;
    logic [63:0]        mag;
    logic               escaped;
    logic               out_busy;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        c_real_next = c_real_reg;
        c_imag_next = c_imag_reg;
        prec_next   = prec_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                jet_pkg::REG_C_REAL:    c_real_next = cfg_data;
                jet_pkg::REG_C_IMAG:    c_imag_next = cfg_data;
                jet_pkg::REG_PRECISION: prec_next   = cfg_data[jet_pkg::PREC_W-1:0];
                default:                prec_next   = prec_reg;
            endcase
        end
    end

    assign out_busy = out_valid_reg && !out_ready;

    jet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .prec     (prec_reg),
        .escaped  (escaped),
        .out_busy (out_busy),
        .ctl      (ctl)
    );

    always_comb
    begin
        unique case (ctl.op)
            jet_pkg::OP_RR:
            begin
                mul_a = re_reg;
                mul_b = re_reg;
            end
            jet_pkg::OP_II:
            begin
                mul_a = im_reg;
                mul_b = im_reg;
            end
            jet_pkg::OP_RI:
            begin
                mul_a = re_reg;
                mul_b = im_reg;
            end
            default:
            begin
                mul_a = re_reg;
                mul_b = re_reg;
            end
        endcase
    end

    jet_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // squares of the new z double as next iteration's re^2 and im^2
    assign mag     = $unsigned(rr_reg) + $unsigned(ii_reg);
    assign escaped = (mag >= jet_pkg::MAG_THRESH);

    assign diff    = rr_reg - ii_reg;
    assign nr_wide = (diff >>> jet_pkg::FRAC_BITS) + 64'(c_real_reg);
    assign ni_wide = (ri_reg >>> (jet_pkg::FRAC_BITS - 1)) + 64'(c_imag_reg);

    always_comb
    begin
        re_next = re_reg;
        im_next = im_reg;
        if (ctl.load)
        begin
            re_next = point_real;
            im_next = point_imag;
        end
        else if (ctl.update)
        begin
            re_next = jet_pkg::sat32(nr_wide);
            im_next = jet_pkg::sat32(ni_wide);
        end
    end

    assign rr_next = ctl.cap_rr ? prod : rr_reg;
    assign ii_next = ctl.cap_ii ? prod : ii_reg;
    assign ri_next = ctl.cap_ri ? prod : ri_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        level_next     = level_reg;
        if (ctl.finish)
        begin
            out_valid_next = 1'b1;
            level_next     = ctl.res;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_real_reg    <= jet_pkg::C_REAL_RST;
            c_imag_reg    <= jet_pkg::C_IMAG_RST;
            prec_reg      <= jet_pkg::PRECISION_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            c_real_reg    <= c_real_next;
            c_imag_reg    <= c_imag_next;
            prec_reg      <= prec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg    <= re_next;
        im_reg    <= im_next;
        rr_reg    <= rr_next;
        ii_reg    <= ii_next;
        ri_reg    <= ri_next;
        level_reg <= level_next;
    end

    assign in_ready  = ctl.in_ready;
    assign out_valid = out_valid_reg;
    assign level     = level_reg;

endmodule
